// ===== design/lph_pkg.sv =====
// Shared constants, codes and types of the linear-probe hash table.
`timescale 1ns / 1ps

package lph_pkg;

    // Table geometry; the depth is a power of two so the home slot is a bit mask.
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;

    // Field widths of one item.
    localparam int KEY_BYTES   = 8;
    localparam int VALUE_BYTES = 4;
    localparam int KEY_W       = 8 * KEY_BYTES;
    localparam int VALUE_W     = 8 * VALUE_BYTES;
    localparam int KLEN_W      = 4;
    localparam int VLEN_W      = 3;
    localparam int ACTION_W    = 2;
    localparam int STATUS_W    = 3;
    localparam int TOTAL_W     = 5;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT  = 2'd0,
        ACT_LOOKUP  = 2'd1,
        ACT_REPLACE = 2'd2,
        ACT_REMOVE  = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_INSERTED = 3'd0,
        STATUS_PRESENT  = 3'd1,
        STATUS_FULL     = 3'd2,
        STATUS_FOUND    = 3'd3,
        STATUS_MISSING  = 3'd4,
        STATUS_UPDATED  = 3'd5,
        STATUS_REMOVED  = 3'd6
    } status_t;

    // One slot as it is kept in the slot memory.
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [KLEN_W-1:0]  key_len;
        logic [VALUE_W-1:0] value;
        logic [VLEN_W-1:0]  value_len;
    } slot_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        slot_t            data;
    } ram_wr_t;

    typedef struct packed {
        logic             re;
        logic [IDX_W-1:0] addr;
    } ram_rd_t;

endpackage

// ===== design/lph_req_if.sv =====
// Request channel: action, key and value of one item with a valid/ready handshake.
`timescale 1ns / 1ps

interface lph_req_if;
    logic                          valid;
    logic                          ready;
    logic [lph_pkg::ACTION_W-1:0]  action;
    logic [lph_pkg::KEY_W-1:0]     key;
    logic [lph_pkg::KLEN_W-1:0]    key_len;
    logic [lph_pkg::VALUE_W-1:0]   value;
    logic [lph_pkg::VLEN_W-1:0]    value_len;

    modport source (output valid, action, key, key_len, value, value_len, input ready);
    modport sink   (input valid, action, key, key_len, value, value_len, output ready);
endinterface

// ===== design/lph_rsp_if.sv =====
// Response channel: status and lookup result of one item with a valid/ready handshake.
`timescale 1ns / 1ps

interface lph_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [lph_pkg::STATUS_W-1:0]  status;
    logic [lph_pkg::VALUE_W-1:0]   found_value;
    logic [lph_pkg::VLEN_W-1:0]    found_value_len;
    logic [lph_pkg::TOTAL_W-1:0]   entry_total;

    modport source (output valid, status, found_value, found_value_len, entry_total,
                    input ready);
    modport sink   (input valid, status, found_value, found_value_len, entry_total,
                    output ready);
endinterface

// ===== design/lph_slot_ram.sv =====
// Slot memory: one write port and one read port with registered read data.
`timescale 1ns / 1ps

module lph_slot_ram (
    input  logic             clk,
    input  lph_pkg::ram_wr_t wr,
    input  lph_pkg::ram_rd_t rd,
    output lph_pkg::slot_t   rdata
);
    import lph_pkg::*;

    slot_t mem [TABLE_DEPTH];
    slot_t rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge clk)
    begin
        if (rd.re)
        begin
            rdata_reg <= mem[rd.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/lph_ctrl.sv =====
// Probe sequencer: slot flags, entry count, probe walk and result register.
`timescale 1ns / 1ps

module lph_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    lph_req_if.sink          req,
    lph_rsp_if.source        rsp,
    output lph_pkg::ram_wr_t ram_wr,
    output lph_pkg::ram_rd_t ram_rd,
    input  lph_pkg::slot_t   ram_rdata
);
    import lph_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_APPLY
    } state_t;

    state_t               state_reg;
    action_t              action_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [KLEN_W-1:0]    klen_reg;
    logic [VALUE_W-1:0]   value_reg;
    logic [VLEN_W-1:0]    vlen_reg;
    logic [IDX_W-1:0]     home_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 pend_reg;
    logic [IDX_W-1:0]     pend_slot_reg;
    logic                 hit_reg;
    logic [IDX_W-1:0]     hit_slot_reg;
    logic [VALUE_W-1:0]   hit_value_reg;
    logic [VLEN_W-1:0]    hit_vlen_reg;
    logic                 free_found_reg;
    logic [IDX_W-1:0]     free_slot_reg;
    logic                 used_reg [TABLE_DEPTH];
    logic                 tomb_reg [TABLE_DEPTH];
    logic [TOTAL_W-1:0]   count_reg;
    logic                 out_valid_reg;
    status_t              out_status_reg;
    logic [VALUE_W-1:0]   out_value_reg;
    logic [VLEN_W-1:0]    out_vlen_reg;
    logic [TOTAL_W-1:0]   out_total_reg;

    logic                 accept;
    logic [KLEN_W-1:0]    klen_sat;
    logic [VLEN_W-1:0]    vlen_sat;
    logic [KEY_W-1:0]     key_norm;
    logic [VALUE_W-1:0]   value_norm;
    logic [7:0]           hash;
    logic [IDX_W-1:0]     probe_idx;
    logic                 issuing;
    logic                 hit_now;
    logic                 apply_go;
    status_t              status_next;
    logic [TOTAL_W-1:0]   count_next;
    logic                 do_insert;
    logic                 do_replace;
    logic                 do_remove;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);

    // Saturate the lengths, clear the stray bytes and fold the key into a home slot.
    always_comb
    begin
        klen_sat = (req.key_len > KLEN_W'(KEY_BYTES)) ? KLEN_W'(KEY_BYTES) : req.key_len;
        vlen_sat = (req.value_len > VLEN_W'(VALUE_BYTES)) ? VLEN_W'(VALUE_BYTES)
                                                          : req.value_len;
        hash = '0;
        for (int b = 0; b < KEY_BYTES; b++)
        begin
            key_norm[8*b +: 8] = (KLEN_W'(b) < klen_sat) ? req.key[8*b +: 8] : 8'h00;
            hash = hash ^ key_norm[8*b +: 8];
        end
        for (int b = 0; b < VALUE_BYTES; b++)
        begin
            value_norm[8*b +: 8] = (VLEN_W'(b) < vlen_sat) ? req.value[8*b +: 8] : 8'h00;
        end
    end

    // Probe walk: one slot is issued per cycle while the previous slot's key is compared.
    assign probe_idx = home_reg + cnt_reg[IDX_W-1:0];
    assign issuing   = (cnt_reg != CNT_W'(TABLE_DEPTH));
    assign hit_now   = pend_reg && (ram_rdata.key == key_reg)
                       && (ram_rdata.key_len == klen_reg);

    assign ram_rd.re   = (state_reg == S_PROBE) && !hit_now && issuing && used_reg[probe_idx];
    assign ram_rd.addr = probe_idx;

    // Outcome of the request once the walk has ended.
    assign apply_go = (state_reg == S_APPLY) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        do_insert   = 1'b0;
        do_replace  = 1'b0;
        do_remove   = 1'b0;
        status_next = STATUS_MISSING;
        case (action_reg)
            ACT_INSERT:
            begin
                if (hit_reg)
                begin
                    status_next = STATUS_PRESENT;
                end
                else if (free_found_reg)
                begin
                    status_next = STATUS_INSERTED;
                    do_insert   = 1'b1;
                end
                else
                begin
                    status_next = STATUS_FULL;
                end
            end
            ACT_LOOKUP:
            begin
                status_next = hit_reg ? STATUS_FOUND : STATUS_MISSING;
            end
            ACT_REPLACE:
            begin
                status_next = hit_reg ? STATUS_UPDATED : STATUS_MISSING;
                do_replace  = hit_reg;
            end
            default:
            begin
                status_next = hit_reg ? STATUS_REMOVED : STATUS_MISSING;
                do_remove   = hit_reg;
            end
        endcase

        count_next = count_reg;
        if (do_insert)
        begin
            count_next = count_reg + TOTAL_W'(1);
        end
        else if (do_remove && (count_reg != '0))
        begin
            count_next = count_reg - TOTAL_W'(1);
        end
    end

    // Write-back of a new slot or of a replaced value.
    always_comb
    begin
        ram_wr.we             = apply_go && (do_insert || do_replace);
        ram_wr.addr           = do_insert ? free_slot_reg : hit_slot_reg;
        ram_wr.data.key       = key_reg;
        ram_wr.data.key_len   = klen_reg;
        ram_wr.data.value     = value_reg;
        ram_wr.data.value_len = vlen_reg;
    end

    // Sequencer state, slot flags, entry count and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            action_reg     <= ACT_INSERT;
            key_reg        <= '0;
            klen_reg       <= '0;
            value_reg      <= '0;
            vlen_reg       <= '0;
            home_reg       <= '0;
            cnt_reg        <= '0;
            pend_reg       <= 1'b0;
            pend_slot_reg  <= '0;
            hit_reg        <= 1'b0;
            hit_slot_reg   <= '0;
            hit_value_reg  <= '0;
            hit_vlen_reg   <= '0;
            free_found_reg <= 1'b0;
            free_slot_reg  <= '0;
            for (int s = 0; s < TABLE_DEPTH; s++)
            begin
                used_reg[s] <= 1'b0;
                tomb_reg[s] <= 1'b0;
            end
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= STATUS_INSERTED;
            out_value_reg  <= '0;
            out_vlen_reg   <= '0;
            out_total_reg  <= '0;
        end
        else
        begin
            // A taken result empties the register unless a new one is loaded.
            if (out_valid_reg && rsp.ready && !apply_go)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        action_reg     <= action_t'(req.action);
                        key_reg        <= key_norm;
                        klen_reg       <= klen_sat;
                        value_reg      <= value_norm;
                        vlen_reg       <= vlen_sat;
                        home_reg       <= hash[IDX_W-1:0];
                        cnt_reg        <= '0;
                        pend_reg       <= 1'b0;
                        hit_reg        <= 1'b0;
                        free_found_reg <= 1'b0;
                        state_reg      <= S_PROBE;
                    end
                end
                S_PROBE:
                begin
                    if (hit_now)
                    begin
                        hit_reg       <= 1'b1;
                        hit_slot_reg  <= pend_slot_reg;
                        hit_value_reg <= ram_rdata.value;
                        hit_vlen_reg  <= ram_rdata.value_len;
                        state_reg     <= S_APPLY;
                    end
                    else if (!issuing)
                    begin
                        state_reg <= S_APPLY;
                    end
                    else
                    begin
                        cnt_reg       <= cnt_reg + CNT_W'(1);
                        pend_reg      <= used_reg[probe_idx];
                        pend_slot_reg <= probe_idx;
                        if (!used_reg[probe_idx])
                        begin
                            if (!free_found_reg)
                            begin
                                free_found_reg <= 1'b1;
                                free_slot_reg  <= probe_idx;
                            end
                            // A never-used slot ends the chain.
                            if (!tomb_reg[probe_idx])
                            begin
                                state_reg <= S_APPLY;
                            end
                        end
                    end
                end
                S_APPLY:
                begin
                    if (apply_go)
                    begin
                        if (do_insert)
                        begin
                            used_reg[free_slot_reg] <= 1'b1;
                            tomb_reg[free_slot_reg] <= 1'b0;
                        end
                        if (do_remove)
                        begin
                            used_reg[hit_slot_reg] <= 1'b0;
                            tomb_reg[hit_slot_reg] <= 1'b1;
                        end
                        count_reg      <= count_next;
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= status_next;
                        out_value_reg  <= (status_next == STATUS_FOUND) ? hit_value_reg : '0;
                        out_vlen_reg   <= (status_next == STATUS_FOUND) ? hit_vlen_reg : '0;
                        out_total_reg  <= count_next;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.found_value     = out_value_reg;
    assign rsp.found_value_len = out_vlen_reg;
    assign rsp.entry_total     = out_total_reg;

endmodule

// ===== design/linear_probe_hash_table_top.sv =====
// The sequencer takes one item at a time: a request item is taken only in the idle state,
// and the probe reads one slot per cycle from the single read port of the slot memory,
// up to 16 slots, before the compare, the write-back and the return to idle. The result
// register lets the next item be taken while a result waits.
// Reset clears the slot flags and entry count at once; no clearing pass is needed.
`timescale 1ns / 1ps

module linear_probe_hash_table_top (
    input  logic      clk,
    input  logic      rst_n,
    lph_req_if.sink   req,
    lph_rsp_if.source rsp
);
    import lph_pkg::*;

    ram_wr_t ram_wr;
    ram_rd_t ram_rd;
    slot_t   ram_rdata;

    // Probe sequencer with slot flags and result register.
    lph_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .ram_wr    (ram_wr),
        .ram_rd    (ram_rd),
        .ram_rdata (ram_rdata)
    );

    // Key and value storage of all slots.
    lph_slot_ram u_slot_ram (
        .clk   (clk),
        .wr    (ram_wr),
        .rd    (ram_rd),
        .rdata (ram_rdata)
    );

endmodule

// ===== tb/sv/linear_probe_hash_table_top_tb.sv =====
// Testbench for the linear-probe hash table: directed and random requests checked by a shadow.
`timescale 1ns / 1ps

module linear_probe_hash_table_top_tb;

    import lph_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_ITEMS = 420;
    localparam int POOL_SIZE    = 24;
    // Margin after the results have drained, before the final verdict.
    localparam int SETTLE_CYCLES = 40;
    // Watchdog limit on a quiet span; it covers a sender gap, a probe and a result stall.
    localparam int IDLE_LIMIT = 2000;

    // One request item as driven on the request channel.
    typedef struct {
        action_t            action;
        logic [KEY_W-1:0]   key;
        logic [KLEN_W-1:0]  key_len;
        logic [VALUE_W-1:0] value;
        logic [VLEN_W-1:0]  value_len;
    } request_t;

    // One result item as seen on the response channel.
    typedef struct {
        status_t             status;
        logic [VALUE_W-1:0]  found_value;
        logic [VLEN_W-1:0]   found_value_len;
        logic [TOTAL_W-1:0]  entry_total;
    } outcome_t;

    // A directed row; the outcome is used only when it is typed in.
    typedef struct {
        request_t item;
        bit       typed;
        outcome_t outcome;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    lph_req_if req ();
    lph_rsp_if rsp ();

    linear_probe_hash_table_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Shadow copy of the table contents.
    logic [KEY_W-1:0]   shadow_key       [TABLE_DEPTH];
    int                 shadow_key_len   [TABLE_DEPTH];
    logic [VALUE_W-1:0] shadow_value     [TABLE_DEPTH];
    logic [VLEN_W-1:0]  shadow_value_len [TABLE_DEPTH];
    bit                 shadow_used      [TABLE_DEPTH];
    bit                 shadow_tomb      [TABLE_DEPTH];
    int                 shadow_live;

    // Keys that are reused so that requests hit stored entries.
    logic [KEY_W-1:0] pool_key [POOL_SIZE];
    int               pool_len [POOL_SIZE];

    outcome_t  pending_results [$];
    stim_row_t directed_rows   [$];
    int        mismatch_count = 0;
    bit        req_gaps_on    = 1'b0;
    bit        rsp_stalls_on  = 1'b0;

    always #HALF_PERIOD clk = ~clk;

    // Applies one request to the shadow table and returns the result it must cause.
    function automatic outcome_t apply_request(request_t r);
        logic [KEY_W-1:0]   k;
        logic [VALUE_W-1:0] v;
        logic [63:0]        vmask;
        logic [7:0]         fold;
        int                 klen;
        int                 vlen;
        int                 home;
        int                 hit;
        int                 free_slot;
        int                 s;
        outcome_t           o;

        // Saturate the lengths and drop the bytes above them.
        klen = (r.key_len > KEY_BYTES) ? KEY_BYTES : int'(r.key_len);
        vlen = (r.value_len > VALUE_BYTES) ? VALUE_BYTES : int'(r.value_len);
        k = r.key;
        if (klen < KEY_BYTES)
            k = k & ((64'd1 << (8 * klen)) - 64'd1);
        vmask = (64'd1 << (8 * vlen)) - 64'd1;
        v = r.value & vmask[VALUE_W-1:0];

        // Home slot is the XOR of the valid key bytes.
        fold = 8'd0;
        for (int b = 0; b < klen; b++)
            fold ^= k[8*b +: 8];
        home = int'(fold) % TABLE_DEPTH;

        // Walk the chain until a never-used slot or a full lap.
        hit = TABLE_DEPTH;
        free_slot = TABLE_DEPTH;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            s = (home + i) % TABLE_DEPTH;
            if (shadow_used[s])
            begin
                if (shadow_key_len[s] == klen && shadow_key[s] == k)
                begin
                    hit = s;
                    break;
                end
            end
            else
            begin
                if (free_slot == TABLE_DEPTH)
                    free_slot = s;
                if (!shadow_tomb[s])
                    break;
            end
        end

        o.found_value = '0;
        o.found_value_len = '0;
        if (r.action == ACT_INSERT)
        begin
            if (hit < TABLE_DEPTH)
            begin
                o.status = STATUS_PRESENT;
            end
            else if (free_slot >= TABLE_DEPTH)
            begin
                o.status = STATUS_FULL;
            end
            else
            begin
                shadow_key[free_slot]       = k;
                shadow_key_len[free_slot]   = klen;
                shadow_value[free_slot]     = v;
                shadow_value_len[free_slot] = VLEN_W'(vlen);
                shadow_used[free_slot]      = 1'b1;
                shadow_tomb[free_slot]      = 1'b0;
                shadow_live++;
                o.status = STATUS_INSERTED;
            end
        end
        else if (hit >= TABLE_DEPTH)
        begin
            o.status = STATUS_MISSING;
        end
        else if (r.action == ACT_LOOKUP)
        begin
            o.found_value     = shadow_value[hit];
            o.found_value_len = shadow_value_len[hit];
            o.status = STATUS_FOUND;
        end
        else if (r.action == ACT_REPLACE)
        begin
            shadow_value[hit]     = v;
            shadow_value_len[hit] = VLEN_W'(vlen);
            o.status = STATUS_UPDATED;
        end
        else
        begin
            shadow_used[hit] = 1'b0;
            shadow_tomb[hit] = 1'b1;
            if (shadow_live > 0)
                shadow_live--;
            o.status = STATUS_REMOVED;
        end
        o.entry_total = TOTAL_W'(shadow_live);
        return o;
    endfunction

    function automatic void add_row(action_t a, logic [63:0] k, int kl, logic [31:0] v, int vl,
                                    bit typed = 1'b0, status_t st = STATUS_INSERTED,
                                    logic [31:0] fv = '0, int fl = 0, int total = 0);
        stim_row_t row;

        row.item.action          = a;
        row.item.key             = k;
        row.item.key_len         = KLEN_W'(kl);
        row.item.value           = v;
        row.item.value_len       = VLEN_W'(vl);
        row.typed                = typed;
        row.outcome.status          = st;
        row.outcome.found_value     = fv;
        row.outcome.found_value_len = VLEN_W'(fl);
        row.outcome.entry_total     = TOTAL_W'(total);
        directed_rows.push_back(row);
    endfunction

    // Mostly short gaps, a few long ones.
    function automatic int pick_gap();
        int r;

        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void refresh_pool_entry(int p);
        pool_len[p] = $urandom_range(0, KEY_BYTES);
        pool_key[p] = {$urandom, $urandom};
        if (pool_len[p] < KEY_BYTES)
            pool_key[p] &= (64'd1 << (8 * pool_len[p])) - 64'd1;
    endfunction

    // A request on a pooled key, with stray high bytes or an oversized length at times.
    function automatic request_t pool_request(action_t a);
        request_t    r;
        int          p;
        logic [63:0] mask;

        p = $urandom_range(0, POOL_SIZE - 1);
        r.action = a;
        r.key = pool_key[p];
        mask = (pool_len[p] < KEY_BYTES) ? ((64'd1 << (8 * pool_len[p])) - 64'd1) : '1;
        if ($urandom_range(0, 1) == 1)
            r.key |= {$urandom, $urandom} & ~mask;
        if (pool_len[p] == KEY_BYTES && $urandom_range(0, 3) == 0)
            r.key_len = KLEN_W'($urandom_range(KEY_BYTES, 15));
        else
            r.key_len = KLEN_W'(pool_len[p]);
        r.value = $urandom;
        r.value_len = VLEN_W'($urandom_range(0, 7));
        return r;
    endfunction

    function automatic request_t noise_request();
        request_t r;

        r.action    = action_t'($urandom_range(0, 3));
        r.key       = {$urandom, $urandom};
        r.key_len   = KLEN_W'($urandom_range(0, 15));
        r.value     = $urandom;
        r.value_len = VLEN_W'($urandom_range(0, 7));
        return r;
    endfunction

    // Drives one item, waits for it to be taken, then records the result it must cause.
    task automatic send_request(request_t item, bit typed, outcome_t typed_outcome);
        int       gap;
        outcome_t predicted;

        gap = req_gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid     <= 1'b1;
        req.action    <= item.action;
        req.key       <= item.key;
        req.key_len   <= item.key_len;
        req.value     <= item.value;
        req.value_len <= item.value_len;
        @(posedge clk);
        while (req.ready !== 1'b1)
            @(posedge clk);
        predicted = apply_request(item);
        pending_results.push_back(typed ? typed_outcome : predicted);
    endtask

    // Holds the sender off until every outstanding result has come back.
    task automatic wait_results_drained();
        req.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic check_field(string field_name, logic [63:0] expected, logic [63:0] actual);
        if (actual !== expected)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", field_name, expected, actual);
            mismatch_count++;
        end
    endtask

    // Result side: random stalls on ready, and each accepted item compared in order.
    initial
    begin
        outcome_t want;
        int       stall_left;
        int       gap;

        stall_left = 0;
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result item with no request outstanding");
                    mismatch_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("status", want.status, rsp.status);
                    check_field("found_value", want.found_value, rsp.found_value);
                    check_field("found_value_len", want.found_value_len, rsp.found_value_len);
                    check_field("entry_total", want.entry_total, rsp.entry_total);
                end
            end
            gap = (rsp_stalls_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
            if (stall_left > 0)
            begin
                stall_left--;
                rsp.ready <= 1'b0;
            end
            else if (gap > 0)
            begin
                stall_left = gap - 1;
                rsp.ready <= 1'b0;
            end
            else
            begin
                rsp.ready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run when nothing moves on either channel for too long.
    initial
    begin
        int idle_cycles;

        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (rst_n !== 1'b1 || (req.valid === 1'b1 && req.ready === 1'b1)
                    || (rsp.valid === 1'b1 && rsp.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // Stimulus.
    initial
    begin
        outcome_t no_outcome;
        int       random_sent;
        int       kind;
        int       len;
        int       pick;
        action_t  act;

        rst_n         <= 1'b0;
        req.valid     <= 1'b0;
        req.action    <= ACT_INSERT;
        req.key       <= '0;
        req.key_len   <= '0;
        req.value     <= '0;
        req.value_len <= '0;
        no_outcome    = '{STATUS_INSERTED, '0, '0, '0};

        shadow_live = 0;
        for (int s = 0; s < TABLE_DEPTH; s++)
        begin
            shadow_used[s] = 1'b0;
            shadow_tomb[s] = 1'b0;
        end
        for (int p = 0; p < POOL_SIZE; p++)
            refresh_pool_entry(p);

        // Empty table: every request on an absent key.
        add_row(ACT_LOOKUP,  64'h0, 1, 32'h0, 0, 1'b1, STATUS_MISSING, 32'h0, 0, 0);
        add_row(ACT_REMOVE,  64'hFFFF_FFFF_FFFF_FFFF, 8, 32'h0, 0,
                1'b1, STATUS_MISSING, 32'h0, 0, 0);
        add_row(ACT_REPLACE, 64'h5, 1, 32'h1, 1, 1'b1, STATUS_MISSING, 32'h0, 0, 0);
        // All-ones key and value; the key folds to the home slot zero.
        add_row(ACT_INSERT,  64'hFFFF_FFFF_FFFF_FFFF, 8, 32'hFFFF_FFFF, 4,
                1'b1, STATUS_INSERTED, 32'h0, 0, 1);
        // Long key length saturates to the full key.
        add_row(ACT_LOOKUP,  64'hFFFF_FFFF_FFFF_FFFF, 15, 32'h0, 0,
                1'b1, STATUS_FOUND, 32'hFFFF_FFFF, 4, 1);
        add_row(ACT_INSERT,  64'hFFFF_FFFF_FFFF_FFFF, 8, 32'h0, 0,
                1'b1, STATUS_PRESENT, 32'h0, 0, 1);
        // Empty key, and a long value length that saturates.
        add_row(ACT_INSERT,  64'h0, 0, 32'h1234_5678, 7, 1'b1, STATUS_INSERTED, 32'h0, 0, 2);
        add_row(ACT_LOOKUP,  64'hDEAD_BEEF_CAFE_F00D, 0, 32'h0, 0,
                1'b1, STATUS_FOUND, 32'h1234_5678, 4, 2);
        // Stray key and value bytes above the lengths.
        add_row(ACT_INSERT,  64'hAAAA_AAAA_AAAA_AA01, 1, 32'hFFFF_FFFF, 2,
                1'b1, STATUS_INSERTED, 32'h0, 0, 3);
        add_row(ACT_LOOKUP,  64'h01, 1, 32'h0, 0, 1'b1, STATUS_FOUND, 32'h0000_FFFF, 2, 3);
        // Same bytes but a different length is another key.
        add_row(ACT_LOOKUP,  64'h01, 2, 32'h0, 0, 1'b1, STATUS_MISSING, 32'h0, 0, 3);
        add_row(ACT_REPLACE, 64'h01, 1, 32'hA5A5_A5A5, 0, 1'b1, STATUS_UPDATED, 32'h0, 0, 3);
        add_row(ACT_LOOKUP,  64'h01, 1, 32'h0, 0, 1'b1, STATUS_FOUND, 32'h0, 0, 3);
        add_row(ACT_REMOVE,  64'h0, 0, 32'h0, 0, 1'b1, STATUS_REMOVED, 32'h0, 0, 2);
        // Probes through a tombstone, and an insert that reuses it.
        add_row(ACT_LOOKUP,  64'h01, 1, 32'h0, 0);
        add_row(ACT_INSERT,  64'h11, 1, 32'h55, 1);
        add_row(ACT_REMOVE,  64'hFFFF_FFFF_FFFF_FFFF, 9, 32'h0, 0);
        add_row(ACT_LOOKUP,  64'h11, 1, 32'h0, 0);
        add_row(ACT_INSERT,  64'h01, 1, 32'h77, 1);
        add_row(ACT_INSERT,  64'h0101, 2, 32'h8000_0001, 5);
        add_row(ACT_REPLACE, 64'h11, 1, 32'hFFFF_FFFF, 3);
        add_row(ACT_LOOKUP,  64'h11, 1, 32'h0, 0);
        add_row(ACT_REMOVE,  64'h22, 1, 32'h0, 0);
        add_row(ACT_LOOKUP,  64'h8000_0000_0000_0000, 8, 32'h0, 0);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].outcome);
        wait_results_drained();

        // Random part: fill bursts, drain bursts, mixed traffic on pooled keys, and noise.
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            req_gaps_on   = ($urandom_range(0, 3) != 0);
            rsp_stalls_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 5) == 0)
                wait_results_drained();
            kind = $urandom_range(0, 9);
            if (kind <= 2)
            begin
                len = $urandom_range(10, 20);
                for (int n = 0; n < len; n++)
                    send_request(pool_request(ACT_INSERT), 1'b0, no_outcome);
            end
            else if (kind <= 4)
            begin
                len = $urandom_range(6, 16);
                for (int n = 0; n < len; n++)
                    send_request(pool_request(ACT_REMOVE), 1'b0, no_outcome);
            end
            else if (kind <= 8)
            begin
                len = $urandom_range(8, 20);
                for (int n = 0; n < len; n++)
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 3)
                        act = ACT_INSERT;
                    else if (pick < 6)
                        act = ACT_LOOKUP;
                    else if (pick < 8)
                        act = ACT_REPLACE;
                    else
                        act = ACT_REMOVE;
                    send_request(pool_request(act), 1'b0, no_outcome);
                end
            end
            else
            begin
                len = $urandom_range(3, 8);
                for (int n = 0; n < len; n++)
                    send_request(noise_request(), 1'b0, no_outcome);
                refresh_pool_entry($urandom_range(0, POOL_SIZE - 1));
            end
            random_sent += len;
        end

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
design/lph_pkg.sv
design/lph_req_if.sv
design/lph_rsp_if.sv
design/lph_slot_ram.sv
design/lph_ctrl.sv
design/linear_probe_hash_table_top.sv
tb/sv/linear_probe_hash_table_top_tb.sv
